### sv/kwm_pkg.sv
// ============================================================================
// kwm_pkg
// Shared sizes, value type and controller states of the k-way list merge.
// ============================================================================
package kwm_pkg;

  localparam int CAPACITY    = 64;
  localparam int VALUE_WIDTH = 32;

  // index into one store, count that can also hold CAPACITY itself
  localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  // merged store holds two banks: the one being read and the one being built
  localparam int MDEPTH  = 2 * CAPACITY;
  localparam int MADDR_W = IDX_W + 1;

  typedef logic signed [VALUE_WIDTH-1:0] val_t;
  typedef logic [CNT_W-1:0]              cnt_t;
  typedef logic [IDX_W-1:0]              idx_t;
  typedef logic [MADDR_W-1:0]            maddr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MERGE_PRIME,
    ST_MERGE,
    ST_EMIT_PRIME,
    ST_EMIT
  } kwm_state_t;

endpackage

### sv/kwm_ram.sv
// ============================================================================
// kwm_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ============================================================================
module kwm_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### sv/k_way_sorted_list_merge.sv
// ============================================================================
// k_way_sorted_list_merge
// Merges sorted signed lists into one sorted sequence by repeated two-way
// merging through on-chip stores, then streams the merged sequence out.
// ============================================================================
// Usage: feed elements one transaction at a time with start while busy is
// low; each element that does not close a list is taken and busy stays
// low. An item that closes a list (end_of_list or end_of_set)
// starts a merge pass of the list store into the merged store: busy stays
// high through a priming step and the merge, which writes one element per
// cycle, bound by the single read port of each store. An item with
// end_of_set then streams the result: busy stays high through one priming
// step and then one emit step per result (just the priming step for an
// empty set, which returns one result with is_empty set). Each result
// strobe on result_valid shows in the cycle after its emit step, so the
// last one lands in the first cycle with busy low.
// Results are shown for exactly one cycle and cannot be held off; the
// receiver must take every strobe. Ties keep the merged-store element first.
// Elements beyond CAPACITY are dropped and overflowed is raised on every
// result of the set. The stores need no clearing after reset: only written
// entries are read.
module k_way_sorted_list_merge (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] element_value,
  input  logic               has_element,
  input  logic               end_of_list,
  input  logic               end_of_set,
  output logic               result_valid,
  output logic signed [31:0] merged_value,
  output logic               is_last,
  output logic               overflowed,
  output logic               is_empty
);

  kwm_pkg::kwm_state_t state, state_next;

  // control registers
  logic          bank;           // bank of the merged store that holds the sequence
  kwm_pkg::cnt_t list_count;
  kwm_pkg::cnt_t merged_count;
  logic          overflow_flag;
  logic          set_end;        // merge in flight closes the set
  kwm_pkg::cnt_t a_idx;          // merged-store head (also emit index)
  kwm_pkg::cnt_t b_idx;          // list-store head
  kwm_pkg::cnt_t n_idx;          // output count of the merge

  // memory ports
  logic            l_we;
  kwm_pkg::idx_t   l_waddr;
  kwm_pkg::val_t   l_wdata;
  kwm_pkg::idx_t   l_raddr;
  kwm_pkg::val_t   l_rdata;
  logic            m_we;
  kwm_pkg::maddr_t m_waddr;
  kwm_pkg::val_t   m_wdata;
  kwm_pkg::maddr_t m_raddr;
  kwm_pkg::val_t   m_rdata;

  // merge datapath
  logic          accept;
  logic          a_rem;
  logic          b_rem;
  logic          merge_done;
  logic          take_m;
  logic          emit_last;
  kwm_pkg::cnt_t a_next;
  kwm_pkg::cnt_t b_next;

  assign busy   = (state != kwm_pkg::ST_IDLE);
  assign accept = start && !busy;

  assign a_rem      = (a_idx < merged_count);
  assign b_rem      = (b_idx < list_count);
  assign merge_done = (n_idx == kwm_pkg::CNT_W'(kwm_pkg::CAPACITY)) || (!a_rem && !b_rem);
  // ties go to the merged store
  assign take_m     = !b_rem || (a_rem && (m_rdata <= l_rdata));
  assign emit_last  = ((a_idx + kwm_pkg::CNT_W'(1)) == merged_count);

  kwm_ram #(
    .DEPTH (kwm_pkg::CAPACITY),
    .WIDTH (kwm_pkg::VALUE_WIDTH)
  ) u_list_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  kwm_ram #(
    .DEPTH (kwm_pkg::MDEPTH),
    .WIDTH (kwm_pkg::VALUE_WIDTH)
  ) u_merged_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      kwm_pkg::ST_IDLE: begin
        if (accept && (end_of_list || end_of_set)) begin
          state_next = kwm_pkg::ST_MERGE_PRIME;
        end
      end
      kwm_pkg::ST_MERGE_PRIME: begin
        state_next = kwm_pkg::ST_MERGE;
      end
      kwm_pkg::ST_MERGE: begin
        if (merge_done) begin
          state_next = set_end ? kwm_pkg::ST_EMIT_PRIME : kwm_pkg::ST_IDLE;
        end
      end
      kwm_pkg::ST_EMIT_PRIME: begin
        state_next = (merged_count == '0) ? kwm_pkg::ST_IDLE : kwm_pkg::ST_EMIT;
      end
      kwm_pkg::ST_EMIT: begin
        if (emit_last) begin
          state_next = kwm_pkg::ST_IDLE;
        end
      end
      default: state_next = kwm_pkg::ST_IDLE;
    endcase
  end

  // memory control: read addresses run one step ahead so data for the
  // current heads is always on the read ports during the merge and emit
  always_comb begin
    l_we    = accept && has_element && (list_count < kwm_pkg::CNT_W'(kwm_pkg::CAPACITY));
    l_waddr = list_count[kwm_pkg::IDX_W-1:0];
    l_wdata = kwm_pkg::VALUE_WIDTH'(element_value);
    m_we    = 1'b0;
    m_waddr = {~bank, n_idx[kwm_pkg::IDX_W-1:0]};
    m_wdata = take_m ? m_rdata : l_rdata;
    a_next  = a_idx;
    b_next  = b_idx;
    l_raddr = '0;
    m_raddr = {bank, kwm_pkg::IDX_W'(0)};
    case (state)
      kwm_pkg::ST_MERGE: begin
        if (!merge_done) begin
          m_we = 1'b1;
          if (take_m) begin
            a_next = a_idx + kwm_pkg::CNT_W'(1);
          end else begin
            b_next = b_idx + kwm_pkg::CNT_W'(1);
          end
        end
        l_raddr = b_next[kwm_pkg::IDX_W-1:0];
        m_raddr = {bank, a_next[kwm_pkg::IDX_W-1:0]};
      end
      kwm_pkg::ST_EMIT: begin
        a_next  = a_idx + kwm_pkg::CNT_W'(1);
        m_raddr = {bank, a_next[kwm_pkg::IDX_W-1:0]};
      end
      default: begin
        // priming states and idle read the head entries
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= kwm_pkg::ST_IDLE;
      bank          <= 1'b0;
      list_count    <= '0;
      merged_count  <= '0;
      overflow_flag <= 1'b0;
      set_end       <= 1'b0;
      a_idx         <= '0;
      b_idx         <= '0;
      n_idx         <= '0;
      result_valid  <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= 1'b0;
      case (state)
        kwm_pkg::ST_IDLE: begin
          if (accept) begin
            // append the element, or drop it when the list store is full
            if (has_element) begin
              if (l_we) begin
                list_count <= list_count + kwm_pkg::CNT_W'(1);
              end else begin
                overflow_flag <= 1'b1;
              end
            end
            set_end <= end_of_set;
          end
          a_idx <= '0;
          b_idx <= '0;
          n_idx <= '0;
        end
        kwm_pkg::ST_MERGE: begin
          if (merge_done) begin
            // whatever is left did not fit
            overflow_flag <= overflow_flag | a_rem | b_rem;
            merged_count  <= n_idx;
            list_count    <= '0;
            bank          <= ~bank;
            a_idx         <= '0;
          end else begin
            a_idx <= a_next;
            b_idx <= b_next;
            n_idx <= n_idx + kwm_pkg::CNT_W'(1);
          end
        end
        kwm_pkg::ST_EMIT_PRIME: begin
          a_idx <= '0;
          if (merged_count == '0) begin
            // empty set: one marker result, then clear for the next set
            result_valid  <= 1'b1;
            merged_value  <= '0;
            is_last       <= 1'b1;
            is_empty      <= 1'b1;
            overflowed    <= overflow_flag;
            overflow_flag <= 1'b0;
          end
        end
        kwm_pkg::ST_EMIT: begin
          result_valid <= 1'b1;
          merged_value <= 32'(m_rdata);
          is_last      <= emit_last;
          is_empty     <= 1'b0;
          overflowed   <= overflow_flag;
          a_idx        <= a_next;
          if (emit_last) begin
            merged_count  <= '0;
            overflow_flag <= 1'b0;
          end
        end
        default: begin
          // priming a merge needs no register update
        end
      endcase
    end
  end

endmodule

### sv/kwm_checker.sv
// ============================================================================
// kwm_checker
// Port-level checks of the k-way list merge, bound to the top level.
// ============================================================================
module kwm_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic signed [31:0] element_value,
  input logic               has_element,
  input logic               end_of_list,
  input logic               end_of_set,
  input logic               result_valid,
  input logic signed [31:0] merged_value,
  input logic               is_last,
  input logic               overflowed,
  input logic               is_empty
);

  // an empty-set marker is always the only result of its set
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && is_empty |-> is_last)
    else $error("empty-set result without is_last");

  // results of one set come in an unbroken run
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    result_valid && !is_last |=> result_valid && !is_empty)
    else $error("gap inside a result run");

  // nothing follows the last result at once
  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    result_valid && is_last |=> !result_valid)
    else $error("result right after the last one");

  // the block stays busy while a run is in progress
  a_busy_in_run: assert property (@(posedge clk) disable iff (rst)
    result_valid && !is_last |-> busy)
    else $error("idle in the middle of a result run");

  // an element that closes no list is taken without raising busy
  a_load_one_cycle: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !end_of_list && !end_of_set |=> !busy && !result_valid)
    else $error("plain element load did not finish in one cycle");

endmodule

bind k_way_sorted_list_merge kwm_checker u_kwm_checker (.*);
